>>> sv/jsl_pkg.sv
// Shared types, codes and constants of the JPEG frame dimension parser.
// Used by every module of the block; depends on nothing.
package jsl_pkg;

	// Largest frame byte count that the parser treats as valid.
	localparam logic [16:0] MAX_FRAME_BYTES = 17'd65536;
	// Byte position counter saturates here.
	localparam logic [16:0] POS_MAX = 17'd131071;

	localparam logic [11:0] SCREEN_WIDTH_RESET  = 12'd320;
	localparam logic [11:0] SCREEN_HEIGHT_RESET = 12'd240;

	// Depth of the event queue between the parser and the result stage.
	localparam int EVENT_QUEUE_DEPTH = 2;

	// Configuration register indexes.
	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	// Marker bytes.
	localparam logic [7:0] MK_PREFIX = 8'hFF;
	localparam logic [7:0] MK_SOF0   = 8'hC0;
	localparam logic [7:0] MK_SOF1   = 8'hC1;
	localparam logic [7:0] MK_SOF2   = 8'hC2;
	localparam logic [7:0] MK_SOI    = 8'hD8;
	localparam logic [7:0] MK_EOI    = 8'hD9;
	localparam logic [7:0] MK_TEM    = 8'h01;
	localparam logic [7:0] MK_RST0   = 8'hD0;
	localparam logic [7:0] MK_RST7   = 8'hD7;

	typedef enum logic [2:0] {
		PH_SCAN,
		PH_MARK,
		PH_LENHI,
		PH_LENLO,
		PH_SOF,
		PH_FOUND,
		PH_NONE
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_SIZE  = 3'd1,
		ST_SHORT     = 3'd2,
		ST_NO_DIMS   = 3'd3,
		ST_TOO_LARGE = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		EV_BAD_SIZE,
		EV_SHORT,
		EV_FINAL
	} event_kind_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [16:0] frame_size;
		logic        last;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [10:0] x_offset;
		logic [10:0] y_offset;
		logic        clear_bars;
	} out_beat_t;

	// One frame outcome as seen by the parser, before the screen is applied.
	typedef struct packed {
		event_kind_t kind;
		logic        found;
		logic [15:0] width;
		logic [15:0] height;
	} frame_event_t;

	typedef struct packed {
		logic [11:0] width;
		logic [11:0] height;
	} screen_t;

endpackage

>>> sv/jsl_front.sv
// Byte parser: walks the marker structure of a frame and posts one event per frame.
// Depends on jsl_pkg.
module jsl_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  jsl_pkg::in_beat_t     beat,
	output logic                  ev_push,
	output jsl_pkg::frame_event_t ev
);

	logic [16:0]      bp_q, bp_n;
	logic [17:0]      nmp_q, nmp_n;
	jsl_pkg::phase_t  phase_q, phase_n;
	logic [7:0]       seg_hi_q, seg_hi_n;
	logic [15:0]      ph_q, ph_n;
	logic [15:0]      pw_q, pw_n;
	logic             sent_q, sent_n;

	logic [7:0]       b;
	logic [16:0]      fs;
	logic [17:0]      pos_ext;
	logic [17:0]      pos_plus1;
	logic [17:0]      pos_plus9;
	logic [17:0]      fs_ext;
	logic [18:0]      seg_next;
	logic [17:0]      sof_off;
	logic             bad_size;

	assign b         = beat.data_byte;
	assign fs        = beat.frame_size;
	assign pos_ext   = {1'b0, bp_q};
	assign fs_ext    = {1'b0, fs};
	assign pos_plus1 = pos_ext + 18'd1;
	assign pos_plus9 = pos_ext + 18'd9;
	assign seg_next  = {1'b0, nmp_q} + 19'd2 + {3'b000, seg_hi_q, b};
	assign sof_off   = pos_ext - nmp_q;
	assign bad_size  = (fs < 17'd2) || (fs > jsl_pkg::MAX_FRAME_BYTES);

	always_comb begin
		bp_n     = bp_q;
		nmp_n    = nmp_q;
		phase_n  = phase_q;
		seg_hi_n = seg_hi_q;
		ph_n     = ph_q;
		pw_n     = pw_q;
		sent_n   = sent_q;
		ev_push  = 1'b0;
		ev       = '{kind: jsl_pkg::EV_SHORT, found: 1'b0, width: '0, height: '0};

		if (accept && !sent_q) begin
			if (bad_size) begin
				ev_push  = 1'b1;
				ev.kind  = jsl_pkg::EV_BAD_SIZE;
				sent_n   = 1'b1;
			end else begin
				unique case (phase_q)
					jsl_pkg::PH_SCAN: begin
						if (pos_ext == nmp_q) begin
							if (pos_plus9 >= fs_ext) begin
								phase_n = jsl_pkg::PH_NONE;
							end else if (b == jsl_pkg::MK_PREFIX) begin
								phase_n = jsl_pkg::PH_MARK;
							end else begin
								nmp_n = pos_plus1;
							end
						end
					end
					jsl_pkg::PH_MARK: begin
						case (b) inside
							jsl_pkg::MK_SOF0, jsl_pkg::MK_SOF1, jsl_pkg::MK_SOF2: begin
								phase_n = jsl_pkg::PH_SOF;
							end
							jsl_pkg::MK_SOI, jsl_pkg::MK_EOI, jsl_pkg::MK_TEM,
							[jsl_pkg::MK_RST0:jsl_pkg::MK_RST7]: begin
								nmp_n   = pos_plus1;
								phase_n = jsl_pkg::PH_SCAN;
							end
							default: begin
								phase_n = jsl_pkg::PH_LENHI;
							end
						endcase
					end
					jsl_pkg::PH_LENHI: begin
						seg_hi_n = b;
						phase_n  = jsl_pkg::PH_LENLO;
					end
					jsl_pkg::PH_LENLO: begin
						// A segment that would land on or before this byte resumes the
						// scan at the next byte.
						if (seg_next <= {1'b0, pos_ext}) begin
							nmp_n = pos_plus1;
						end else begin
							nmp_n = seg_next[17:0];
						end
						phase_n = jsl_pkg::PH_SCAN;
					end
					jsl_pkg::PH_SOF: begin
						if (sof_off == 18'd5) begin
							ph_n = {b, 8'h00};
						end else if (sof_off == 18'd6) begin
							ph_n = ph_q | {8'h00, b};
						end else if (sof_off == 18'd7) begin
							pw_n = {b, 8'h00};
						end else if (sof_off == 18'd8) begin
							pw_n = pw_q | {8'h00, b};
							if (((pw_q | {8'h00, b}) != 16'd0) && (ph_q != 16'd0)) begin
								phase_n = jsl_pkg::PH_FOUND;
							end else begin
								phase_n = jsl_pkg::PH_NONE;
							end
						end
					end
					default: begin
					end
				endcase

				if (pos_plus1 >= fs_ext) begin
					ev_push   = 1'b1;
					ev.kind   = jsl_pkg::EV_FINAL;
					ev.found  = (phase_n == jsl_pkg::PH_FOUND);
					ev.width  = pw_n;
					ev.height = ph_n;
					sent_n    = 1'b1;
				end else if (beat.last) begin
					ev_push = 1'b1;
					ev.kind = jsl_pkg::EV_SHORT;
					sent_n  = 1'b1;
				end
			end
		end

		if (accept) begin
			if (beat.last) begin
				bp_n     = '0;
				nmp_n    = 18'd2;
				phase_n  = jsl_pkg::PH_SCAN;
				seg_hi_n = '0;
				ph_n     = '0;
				pw_n     = '0;
				sent_n   = 1'b0;
			end else if (bp_q != jsl_pkg::POS_MAX) begin
				bp_n = bp_q + 17'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_q     <= '0;
			nmp_q    <= 18'd2;
			phase_q  <= jsl_pkg::PH_SCAN;
			seg_hi_q <= '0;
			ph_q     <= '0;
			pw_q     <= '0;
			sent_q   <= 1'b0;
		end else begin
			bp_q     <= bp_n;
			nmp_q    <= nmp_n;
			phase_q  <= phase_n;
			seg_hi_q <= seg_hi_n;
			ph_q     <= ph_n;
			pw_q     <= pw_n;
			sent_q   <= sent_n;
		end
	end

endmodule

>>> sv/jsl_queue.sv
// Short event queue between the byte parser and the result stage.
// Depends on jsl_pkg for the event type.
module jsl_queue #(
	parameter int DEPTH = jsl_pkg::EVENT_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  jsl_pkg::frame_event_t push_data,
	input  logic                  pop,
	output logic                  full,
	output logic                  not_empty,
	output jsl_pkg::frame_event_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	jsl_pkg::frame_event_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/jsl_back.sv
// Result stage: applies the screen size to a frame event and holds the result beat.
// Depends on jsl_pkg.
module jsl_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  jsl_pkg::screen_t      screen,
	input  logic                  ev_valid,
	input  jsl_pkg::frame_event_t ev,
	output logic                  ev_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output jsl_pkg::out_beat_t    out_data
);

	logic                out_valid_q;
	jsl_pkg::out_beat_t  out_data_q;
	jsl_pkg::out_beat_t  result;
	logic [15:0]         sw_ext;
	logic [15:0]         sh_ext;
	logic [11:0]         x_gap;
	logic [11:0]         y_gap;

	assign sw_ext = {4'h0, screen.width};
	assign sh_ext = {4'h0, screen.height};
	assign x_gap  = screen.width - ev.width[11:0];
	assign y_gap  = screen.height - ev.height[11:0];

	always_comb begin
		result = '0;
		case (ev.kind)
			jsl_pkg::EV_BAD_SIZE: result.status = jsl_pkg::ST_BAD_SIZE;
			jsl_pkg::EV_SHORT:    result.status = jsl_pkg::ST_SHORT;
			jsl_pkg::EV_FINAL: begin
				if (!ev.found) begin
					result.status = jsl_pkg::ST_NO_DIMS;
				end else if ((ev.width > sw_ext) || (ev.height > sh_ext)) begin
					result.status       = jsl_pkg::ST_TOO_LARGE;
					result.image_width  = ev.width;
					result.image_height = ev.height;
				end else begin
					result.status       = jsl_pkg::ST_OK;
					result.image_width  = ev.width;
					result.image_height = ev.height;
					result.x_offset     = x_gap[11:1];
					result.y_offset     = y_gap[11:1];
					result.clear_bars   = (ev.width < sw_ext) || (ev.height < sh_ext);
				end
			end
			default: result.status = jsl_pkg::ST_NO_DIMS;
		endcase
	end

	assign ev_pop    = ev_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk) begin
		if (ev_pop) begin
			out_data_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ev_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

>>> sv/jpeg_sof_dims_letterbox.sv
// Top level of the JPEG frame dimension parser with letterbox placement.
// Holds the screen registers and joins jsl_front, jsl_queue and jsl_back; uses jsl_pkg.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_data  (jsl_pkg::in_beat_t), one frame byte
//   out      output     out_valid / out_stall out_data (jsl_pkg::out_beat_t), one per frame
//   config   input      wr_en                 wr_index, wr_data (screen width, height)
//
// One byte beat is taken every clock cycle while the event queue is not full. The byte
// parser decides each byte in the cycle it is taken, so the rate is one beat per cycle,
// held by the parser's state loop. A frame's result beat passes the event queue, then the result stage register.
// Input stalls only when the event queue is full, which takes the output side stalled
// while further frames complete. Reset clears all control state and loads the screen
// registers with 320 by 240.
module jpeg_sof_dims_letterbox #(
	parameter int QUEUE_DEPTH = jsl_pkg::EVENT_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  jsl_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output jsl_pkg::out_beat_t out_data,
	input  logic               wr_en,
	input  logic               wr_index,
	input  logic [11:0]        wr_data
);

	jsl_pkg::screen_t      screen_q;
	jsl_pkg::frame_event_t ev;
	jsl_pkg::frame_event_t q_head;
	logic                  ev_push;
	logic                  q_full;
	logic                  q_valid;
	logic                  q_pop;
	logic                  in_accept;

	// Screen registers. The user must see that they are only written while the block is idle,
	// so that the result stage may read them directly; the block itself does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_q.width  <= jsl_pkg::SCREEN_WIDTH_RESET;
			screen_q.height <= jsl_pkg::SCREEN_HEIGHT_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				jsl_pkg::REG_SCREEN_WIDTH:  screen_q.width  <= wr_data;
				jsl_pkg::REG_SCREEN_HEIGHT: screen_q.height <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// The parser never has to hold a byte back: a full queue is the only stall source.
	assign in_stall  = q_full;
	assign in_accept = in_valid && !q_full;

	jsl_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_accept),
		.beat    (in_data),
		.ev_push (ev_push),
		.ev      (ev)
	);

	jsl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ev_push),
		.push_data (ev),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (q_head)
	);

	jsl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.screen    (screen_q),
		.ev_valid  (q_valid),
		.ev        (q_head),
		.ev_pop    (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	// A placed image always fits inside the screen.
	a_ok_fits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == jsl_pkg::ST_OK) |->
		(out_data.image_width <= {4'h0, screen_q.width}) &&
		(out_data.image_height <= {4'h0, screen_q.height}) &&
		(out_data.image_width != 16'd0) && (out_data.image_height != 16'd0))
		else $error("placed image does not fit the screen");

	// Bars need clearing exactly when the image leaves a gap on either axis.
	a_ok_bars: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == jsl_pkg::ST_OK) |->
		out_data.clear_bars == ((out_data.image_width < {4'h0, screen_q.width}) ||
			(out_data.image_height < {4'h0, screen_q.height})))
		else $error("clear_bars disagrees with the image and screen sizes");

	// Failed frames carry no dimensions and no placement.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((out_data.status == jsl_pkg::ST_BAD_SIZE) ||
			(out_data.status == jsl_pkg::ST_SHORT) ||
			(out_data.status == jsl_pkg::ST_NO_DIMS)) |->
		(out_data.image_width == 16'd0) && (out_data.image_height == 16'd0) &&
		(out_data.x_offset == 11'd0) && (out_data.y_offset == 11'd0) &&
		!out_data.clear_bars)
		else $error("failed frame carries dimensions");

	// An oversized image gets no placement.
	a_large_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == jsl_pkg::ST_TOO_LARGE) |->
		(out_data.x_offset == 11'd0) && (out_data.y_offset == 11'd0) &&
		!out_data.clear_bars &&
		((out_data.image_width > {4'h0, screen_q.width}) ||
			(out_data.image_height > {4'h0, screen_q.height})))
		else $error("oversized result is inconsistent");
`endif

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for jpeg_sof_dims_letterbox: JPEG frames in, one verdict beat out.
// Depends on jsl_pkg and the RTL of the block only.
module tb;

	// Cycles to wait after the last verdict, so that trailing bytes of a frame have left
	// the pipeline before the screen registers are touched.
	localparam int SETTLE_CYCLES  = 6;
	// Cycles without any beat on either channel before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 2000;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	jsl_pkg::in_beat_t  in_data   = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	jsl_pkg::out_beat_t out_data;
	logic               wr_en     = 1'b0;
	logic               wr_index  = jsl_pkg::REG_SCREEN_WIDTH;
	logic [11:0]        wr_data   = '0;

	jpeg_sof_dims_letterbox i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Our own copy of the parser state and the screen registers.
	logic [11:0]      scr_w;
	logic [11:0]      scr_h;
	logic [16:0]      pos;
	logic [17:0]      next_mark;
	jsl_pkg::phase_t  phase;
	logic [7:0]       len_hi;
	logic [15:0]      dim_h;
	logic [15:0]      dim_w;
	logic             verdict_given;

	// Verdicts predicted but not yet seen on the output channel, oldest first.
	jsl_pkg::out_beat_t results_due[$];
	// Bytes of the frame being assembled for sending.
	logic [7:0]  frame_buf[$];

	int          mismatches = 0;
	int          bytes_sent = 0;
	int          idle_cycles = 0;
	int          stall_left = 0;
	// When set, the sender inserts no idle cycles and the result side starts no new stall stretch.
	bit          quiet_mode = 1'b0;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
		end
	endtask

	// Everything about a frame goes back to its reset value after a byte with last set.
	task automatic restart_frame();
		pos           = '0;
		next_mark     = 18'd2;
		phase         = jsl_pkg::PH_SCAN;
		len_hi        = '0;
		dim_h         = '0;
		dim_w         = '0;
		verdict_given = 1'b0;
	endtask

	// Advances the predicted parser by one accepted byte and queues the verdict it causes.
	task automatic track_byte(input jsl_pkg::in_beat_t beat);
		int                 fs;
		int                 p;
		int                 nx;
		int                 off;
		logic [7:0]         b;
		jsl_pkg::out_beat_t r;
		fs = int'(beat.frame_size);
		p  = int'(pos);
		b  = beat.data_byte;
		r  = '0;
		if (!verdict_given) begin
			if (fs < 2 || fs > int'(jsl_pkg::MAX_FRAME_BYTES)) begin
				r.status = jsl_pkg::ST_BAD_SIZE;
				results_due.push_back(r);
				verdict_given = 1'b1;
			end else begin
				case (phase)
					jsl_pkg::PH_SCAN: begin
						// Only the byte where the next marker is due is looked at.
						if (p == int'(next_mark)) begin
							if (p + 9 >= fs) begin
								phase = jsl_pkg::PH_NONE;
							end else if (b == jsl_pkg::MK_PREFIX) begin
								phase = jsl_pkg::PH_MARK;
							end else begin
								next_mark = 18'(p + 1);
							end
						end
					end
					jsl_pkg::PH_MARK: begin
						if (b == jsl_pkg::MK_SOF0 || b == jsl_pkg::MK_SOF1 ||
								b == jsl_pkg::MK_SOF2) begin
							phase = jsl_pkg::PH_SOF;
						end else if (b == jsl_pkg::MK_SOI || b == jsl_pkg::MK_EOI ||
								b == jsl_pkg::MK_TEM ||
								(b >= jsl_pkg::MK_RST0 && b <= jsl_pkg::MK_RST7)) begin
							next_mark = 18'(p + 1);
							phase     = jsl_pkg::PH_SCAN;
						end else begin
							phase = jsl_pkg::PH_LENHI;
						end
					end
					jsl_pkg::PH_LENHI: begin
						len_hi = b;
						phase  = jsl_pkg::PH_LENLO;
					end
					jsl_pkg::PH_LENLO: begin
						// A length that points back at bytes already seen resumes at the
						// next byte instead.
						nx = int'(next_mark) + 2 + int'({len_hi, b});
						next_mark = (nx <= p) ? 18'(p + 1) : 18'(nx);
						phase     = jsl_pkg::PH_SCAN;
					end
					jsl_pkg::PH_SOF: begin
						off = p - int'(next_mark);
						if (off == 5) begin
							dim_h = {b, 8'h00};
						end else if (off == 6) begin
							dim_h[7:0] = b;
						end else if (off == 7) begin
							dim_w = {b, 8'h00};
						end else if (off == 8) begin
							dim_w[7:0] = b;
							phase = (dim_w != 0 && dim_h != 0) ? jsl_pkg::PH_FOUND :
								jsl_pkg::PH_NONE;
						end
					end
					default: begin
					end
				endcase
				if (p + 1 >= fs) begin
					if (phase != jsl_pkg::PH_FOUND) begin
						r.status = jsl_pkg::ST_NO_DIMS;
					end else if (int'(dim_w) > int'(scr_w) || int'(dim_h) > int'(scr_h)) begin
						r.status       = jsl_pkg::ST_TOO_LARGE;
						r.image_width  = dim_w;
						r.image_height = dim_h;
					end else begin
						r.status       = jsl_pkg::ST_OK;
						r.image_width  = dim_w;
						r.image_height = dim_h;
						r.x_offset     = 11'((int'(scr_w) - int'(dim_w)) / 2);
						r.y_offset     = 11'((int'(scr_h) - int'(dim_h)) / 2);
						r.clear_bars   = (int'(dim_w) < int'(scr_w)) ||
							(int'(dim_h) < int'(scr_h));
					end
					results_due.push_back(r);
					verdict_given = 1'b1;
				end else if (beat.last) begin
					r.status = jsl_pkg::ST_SHORT;
					results_due.push_back(r);
					verdict_given = 1'b1;
				end
			end
		end
		if (beat.last) begin
			restart_frame();
		end else if (pos < jsl_pkg::POS_MAX) begin
			pos = pos + 1'b1;
		end
	endtask

	// Sends one byte beat, after a random gap unless quiet. Valid stays high on return so
	// that back-to-back beats need no second assignment in one time step.
	task automatic send_beat(input jsl_pkg::in_beat_t beat);
		int roll;
		int gap;
		gap = 0;
		if (!quiet_mode) begin
			roll = $urandom_range(0, 99);
			if (roll >= 92) begin
				gap = $urandom_range(8, 30);
			end else if (roll >= 60) begin
				gap = $urandom_range(1, 3);
			end
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		track_byte(beat);
		bytes_sent++;
	endtask

	// Sends the assembled frame with the given byte count. With wobble set, some bytes
	// carry a slightly different count, which the block must honor byte by byte.
	task automatic send_frame(input int fs, input bit wobble);
		jsl_pkg::in_beat_t beat;
		int                f;
		for (int i = 0; i < frame_buf.size(); i++) begin
			f = fs;
			if (wobble && $urandom_range(0, 1) == 1) begin
				f = fs + int'($urandom_range(0, 6)) - 3;
			end
			if (f < 0) begin
				f = 0;
			end
			if (f > 131071) begin
				f = 131071;
			end
			beat.data_byte  = frame_buf[i];
			beat.frame_size = 17'(f);
			beat.last       = (i == frame_buf.size() - 1);
			send_beat(beat);
		end
		frame_buf.delete();
	endtask

	task automatic put2(input logic [7:0] b0, input logic [7:0] b1);
		frame_buf.push_back(b0);
		frame_buf.push_back(b1);
	endtask

	// Start-of-frame segment: marker, length, precision, height, width, one component byte.
	task automatic put_sof(input logic [7:0] mk, input logic [15:0] h, input logic [15:0] w);
		put2(jsl_pkg::MK_PREFIX, mk);
		put2(8'h00, 8'h11);
		frame_buf.push_back(8'h08);
		put2(h[15:8], h[7:0]);
		put2(w[15:8], w[7:0]);
		frame_buf.push_back(8'h03);
	endtask

	// Length-prefixed segment with a random marker that is neither SOF nor standalone.
	task automatic put_segment(input int len);
		logic [7:0] mk;
		mk = 8'($urandom_range(0, 255));
		while (mk == jsl_pkg::MK_SOF0 || mk == jsl_pkg::MK_SOF1 || mk == jsl_pkg::MK_SOF2 ||
				mk == jsl_pkg::MK_TEM ||
				(mk >= jsl_pkg::MK_RST0 && mk <= jsl_pkg::MK_EOI)) begin
			mk = 8'($urandom_range(0, 255));
		end
		put2(jsl_pkg::MK_PREFIX, mk);
		put2(8'(len >> 8), 8'(len));
		for (int i = 2; i < len; i++) begin
			frame_buf.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// A well-formed frame with random content: a few leading pieces, an SOF and a tail.
	task automatic build_jpeg();
		int pieces;
		int kind;
		int w;
		int h;
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		pieces = $urandom_range(0, 3);
		for (int i = 0; i < pieces; i++) begin
			kind = $urandom_range(0, 5);
			if (kind == 0) begin
				repeat ($urandom_range(1, 3)) frame_buf.push_back(8'($urandom_range(0, 254)));
			end else if (kind == 1) begin
				kind = $urandom_range(0, 10);
				if (kind < 8) begin
					put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_RST0 + 8'(kind));
				end else if (kind == 8) begin
					put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
				end else if (kind == 9) begin
					put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_EOI);
				end else begin
					put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_TEM);
				end
			end else if (kind == 5) begin
				put_segment($urandom_range(0, 1));
			end else begin
				put_segment($urandom_range(2, 8));
			end
		end
		kind = $urandom_range(0, 9);
		if (kind < 6) begin
			w = $urandom_range(1, scr_w);
			h = $urandom_range(1, scr_h);
		end else if (kind == 6) begin
			w = scr_w;
			h = scr_h;
		end else if (kind == 7) begin
			w = $urandom_range(0, 65535);
			h = $urandom_range(0, 65535);
		end else if (kind == 8) begin
			w = $urandom_range(0, 1) ? 0 : $urandom_range(1, scr_w);
			h = (w == 0) ? $urandom_range(1, scr_h) : 0;
		end else begin
			w = int'(scr_w) + 1;
			h = $urandom_range(1, scr_h);
		end
		put_sof(jsl_pkg::MK_SOF0 + 8'($urandom_range(0, 2)), 16'(h), 16'(w));
		repeat ($urandom_range(1, 3)) frame_buf.push_back(8'($urandom_range(0, 255)));
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_EOI);
	endtask

	// Holds the sender off until every predicted verdict has come out, then lets the tail
	// of the last frame pass through.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Screen registers change only while the block is idle, between frames.
	task automatic set_screen(input logic [11:0] w, input logic [11:0] h);
		drain_results();
		wr_en    <= 1'b1;
		wr_index <= jsl_pkg::REG_SCREEN_WIDTH;
		wr_data  <= w;
		@(posedge clk);
		wr_index <= jsl_pkg::REG_SCREEN_HEIGHT;
		wr_data  <= h;
		@(posedge clk);
		wr_en <= 1'b0;
		scr_w = w;
		scr_h = h;
	endtask

	// Reset screen of 320 by 240: image smaller, equal and larger, and all three SOF kinds.
	task automatic test_reset_screen();
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		put_sof(jsl_pkg::MK_SOF0, 16'd100, 16'd200);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_EOI);
		send_frame(frame_buf.size(), 1'b0);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		put_sof(jsl_pkg::MK_SOF1, 16'd240, 16'd320);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_EOI);
		send_frame(frame_buf.size(), 1'b0);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		put_sof(jsl_pkg::MK_SOF2, 16'd241, 16'd320);
		send_frame(frame_buf.size(), 1'b0);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		put_sof(jsl_pkg::MK_SOF0, 16'd65535, 16'd65535);
		send_frame(frame_buf.size(), 1'b0);
	endtask

	// One frame that walks through junk, each kind of standalone marker, ordinary segments, the
	// tiny lengths 0 and 1 and a doubled prefix before it reaches the SOF.
	task automatic test_marker_walk();
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		put2(8'h12, 8'h34);
		frame_buf.push_back(8'h56);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_RST0);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_RST7);
		put2(jsl_pkg::MK_PREFIX, 8'hD3);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_TEM);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_EOI);
		put2(jsl_pkg::MK_PREFIX, 8'hE0);
		put2(8'h00, 8'h06);
		put2(8'hFF, 8'hC0);
		put2(8'hFF, 8'hAA);
		put2(jsl_pkg::MK_PREFIX, 8'hE1);
		put2(8'h00, 8'h00);
		put2(jsl_pkg::MK_PREFIX, 8'hFE);
		put2(8'h00, 8'h01);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_PREFIX);
		put2(8'h00, 8'h02);
		put_sof(jsl_pkg::MK_SOF0, 16'd50, 16'd60);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_EOI);
		send_frame(frame_buf.size(), 1'b0);
	endtask

	// Bad byte counts, short and minimal frames, missing or zero dimensions, a marker too
	// close to the end, early completion with trailing bytes and a changing byte count.
	task automatic test_frame_faults();
		int counts[4];
		counts = '{0, 1, 65537, 131071};
		foreach (counts[i]) begin
			put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
			put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOF0);
			send_frame(counts[i], 1'b0);
		end
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		send_frame(2, 1'b0);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		put_sof(jsl_pkg::MK_SOF0, 16'd20, 16'd20);
		send_frame(frame_buf.size() + 5, 1'b0);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		put_segment(5);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_EOI);
		send_frame(frame_buf.size(), 1'b0);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		put_sof(jsl_pkg::MK_SOF0, 16'd10, 16'd0);
		send_frame(frame_buf.size(), 1'b0);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		put_sof(jsl_pkg::MK_SOF1, 16'd0, 16'd10);
		send_frame(frame_buf.size(), 1'b0);
		// SOF at byte 2 with a count of 11 fails the margin check by one.
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		put_sof(jsl_pkg::MK_SOF1, 16'd30, 16'd30);
		send_frame(11, 1'b0);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		put_sof(jsl_pkg::MK_SOF2, 16'd30, 16'd40);
		repeat (5) frame_buf.push_back(8'($urandom_range(0, 255)));
		send_frame(13, 1'b0);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		put_sof(jsl_pkg::MK_SOF2, 16'd40, 16'd50);
		repeat (6) frame_buf.push_back(8'($urandom_range(0, 255)));
		send_frame(frame_buf.size(), 1'b1);
	endtask

	// Largest and smallest screens, a lopsided one, and a zero screen that rejects all.
	task automatic test_screen_extremes();
		set_screen(12'd4095, 12'd4095);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		put_sof(jsl_pkg::MK_SOF0, 16'd1, 16'd1);
		send_frame(frame_buf.size(), 1'b0);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		put_sof(jsl_pkg::MK_SOF0, 16'd4095, 16'd4095);
		send_frame(frame_buf.size(), 1'b0);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		put_sof(jsl_pkg::MK_SOF0, 16'd10, 16'd4096);
		send_frame(frame_buf.size(), 1'b0);
		set_screen(12'd1, 12'd1);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		put_sof(jsl_pkg::MK_SOF1, 16'd1, 16'd1);
		send_frame(frame_buf.size(), 1'b0);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		put_sof(jsl_pkg::MK_SOF1, 16'd1, 16'd2);
		send_frame(frame_buf.size(), 1'b0);
		set_screen(12'd4095, 12'd1);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		put_sof(jsl_pkg::MK_SOF2, 16'd1, 16'd1);
		send_frame(frame_buf.size(), 1'b0);
		set_screen(12'd0, 12'd0);
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		put_sof(jsl_pkg::MK_SOF0, 16'd1, 16'd1);
		send_frame(frame_buf.size(), 1'b0);
		set_screen(12'd320, 12'd240);
	endtask

	// The largest valid byte count on a frame that ends early: the count passes the size
	// check, the SOF is parsed and the frame still comes out short.
	task automatic test_largest_frame();
		put2(jsl_pkg::MK_PREFIX, jsl_pkg::MK_SOI);
		put_sof(jsl_pkg::MK_SOF0, 16'd200, 16'd300);
		repeat (8) frame_buf.push_back(8'($urandom_range(0, 255)));
		send_frame(int'(jsl_pkg::MAX_FRAME_BYTES), 1'b0);
	endtask

	// Mostly well-formed frames with random content; the rest is noise, bad counts and
	// truncated frames. The screen changes every eight frames.
	task automatic test_random_frames();
		int frames;
		int roll;
		int fs;
		frames = 0;
		while (bytes_sent < 650 || frames < 8) begin
			if (frames % 8 == 0) begin
				roll = $urandom_range(0, 9);
				case (roll)
					0: begin
						set_screen(12'd4095, 12'd4095);
					end
					1: begin
						set_screen(12'd1, 12'd1);
					end
					2: begin
						set_screen(12'd4095, 12'd1);
					end
					3, 4: begin
						set_screen(12'($urandom_range(16, 640)), 12'($urandom_range(16, 480)));
					end
					default: begin
						set_screen(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)));
					end
				endcase
				quiet_mode = ($urandom_range(0, 4) == 0);
			end
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				build_jpeg();
				fs = frame_buf.size();
				roll = $urandom_range(0, 9);
				if (roll == 0) begin
					send_frame(fs + $urandom_range(1, 6), 1'b0);
				end else if (roll == 1) begin
					send_frame(fs - $urandom_range(1, 3), 1'b0);
				end else begin
					send_frame(fs, roll == 2);
				end
			end else if (roll < 80) begin
				repeat ($urandom_range(2, 24)) frame_buf.push_back(8'($urandom_range(0, 255)));
				send_frame($urandom_range(0, 1) ? frame_buf.size() : $urandom_range(0, 40),
					1'b0);
			end else if (roll < 88) begin
				repeat ($urandom_range(1, 5)) frame_buf.push_back(8'($urandom_range(0, 255)));
				send_frame($urandom_range(0, 1) ? $urandom_range(0, 1) :
					$urandom_range(65537, 131071), 1'b0);
			end else begin
				build_jpeg();
				fs = frame_buf.size();
				repeat ($urandom_range(1, fs - 3)) frame_buf.pop_back();
				send_frame(fs, 1'b0);
			end
			frames++;
		end
		quiet_mode = 1'b0;
	endtask

	// Result side: random stall stretches, mostly short and now and then long.
	always @(posedge clk) begin
		int roll;
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (quiet_mode) begin
			out_stall <= 1'b0;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 75) begin
				out_stall <= 1'b0;
			end else begin
				out_stall  <= 1'b1;
				stall_left <= (roll < 96) ? $urandom_range(0, 2) : $urandom_range(10, 30);
			end
		end
	end

	// Every result beat is matched against the oldest predicted verdict.
	always @(posedge clk) begin
		jsl_pkg::out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				report_mismatch($sformatf("result beat with status %0d but none due",
					out_data.status));
			end else begin
				want = results_due.pop_front();
				check_field("status", out_data.status, want.status);
				check_field("image_width", out_data.image_width, want.image_width);
				check_field("image_height", out_data.image_height, want.image_height);
				check_field("x_offset", out_data.x_offset, want.x_offset);
				check_field("y_offset", out_data.y_offset, want.y_offset);
				check_field("clear_bars", out_data.clear_bars, want.clear_bars);
			end
		end
	end

	// A run with no beat on either channel for too long is hung.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no beat for %0d cycles", $time, idle_cycles);
			$display("** jpeg_sof_dims_letterbox: FAILED **");
			$finish;
		end
	end

	initial begin
		scr_w = jsl_pkg::SCREEN_WIDTH_RESET;
		scr_h = jsl_pkg::SCREEN_HEIGHT_RESET;
		restart_frame();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_screen();
		test_marker_walk();
		test_frame_faults();
		test_screen_extremes();
		test_largest_frame();
		test_random_frames();
		drain_results();
		if (mismatches == 0) begin
			$display("** jpeg_sof_dims_letterbox: PASSED **");
		end else begin
			$display("** jpeg_sof_dims_letterbox: FAILED **");
		end
		$finish;
	end

endmodule
